// ===== hw/rtl/qvr_pkg.sv =====
// Shared constants for the quaternion vector rotation block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  localparam int VECTOR_WIDTH_DEF = 16;
  localparam int QUAT_WIDTH_DEF   = 16;

  // One lane per output axis; each lane also sums this many terms.
  localparam int NUM_LANES = 3;

endpackage

`default_nettype wire

// ===== hw/rtl/quaternion_vector_rotation.sv =====
// Quaternion rotation of a three-axis vector, top level: stream ports,
// pipeline control, three axis lanes and the output merge.
// Depends on qvr_pkg, qvr_matrix and qvr_lane.
//
// Usage: each input beat carries a quaternion in signed Q2.(QUAT_WIDTH-2)
// and a signed vector in s_axis_tdata, with the direction in s_axis_tuser
// (0 body to earth, 1 earth to body). Each output beat carries the rotated
// vector, rounded half up and saturated to VECTOR_WIDTH+1 bits, with the
// saturation flag in m_axis_tuser.
// Throughput is one beat per cycle unless the receiver stalls: a
// six-stage pipeline of quaternion products, matrix entries, split
// partial products, partial sums, rounding and the output register, all
// advanced by one common enable. When the receiver stalls with a beat
// waiting, the whole pipeline holds and s_axis_tready falls in the same
// cycle; it rises again once the waiting beat is taken. Reset empties
// the pipeline; no state outlives a beat.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotation #(
  parameter int VECTOR_WIDTH = qvr_pkg::VECTOR_WIDTH_DEF,
  parameter int QUAT_WIDTH   = qvr_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_in_x, vec_in_y, vec_in_z, zero fill
  input  wire logic [((4*QUAT_WIDTH+3*VECTOR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // direction
  input  wire logic s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // vec_out_x, vec_out_y, vec_out_z, zero fill
  output logic [((3*VECTOR_WIDTH+3+7)/8)*8-1:0] m_axis_tdata,
  // saturated
  output logic      m_axis_tuser
);
  import qvr_pkg::*;

  localparam int QW     = QUAT_WIDTH;
  localparam int VW     = VECTOR_WIDTH;
  localparam int OW     = VW + 1;
  localparam int ODW    = ((3 * OW + 7) / 8) * 8;
  localparam int STAGES = 5;

  logic                 en;
  logic [STAGES-1:0]    vld_q;
  logic                 out_valid_q;
  logic signed [VW-1:0] vec_in [NUM_LANES];
  logic signed [2*QW+1:0] coef [NUM_LANES][NUM_LANES];
  logic signed [VW-1:0] vec_m [NUM_LANES];
  logic signed [OW-1:0] res [NUM_LANES];
  logic [NUM_LANES-1:0] sat;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[STAGES-2:0], s_axis_tvalid};
      out_valid_q <= vld_q[STAGES-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      vec_in[k] = s_axis_tdata[4*QW+k*VW +: VW];
    end
  end

  qvr_matrix #(
    .VECTOR_WIDTH (VECTOR_WIDTH),
    .QUAT_WIDTH   (QUAT_WIDTH)
  ) u_matrix (
    .clk_i       (clk_i),
    .en_i        (en),
    .direction_i (s_axis_tuser),
    .quat_w_i    (s_axis_tdata[0*QW +: QW]),
    .quat_x_i    (s_axis_tdata[1*QW +: QW]),
    .quat_y_i    (s_axis_tdata[2*QW +: QW]),
    .quat_z_i    (s_axis_tdata[3*QW +: QW]),
    .vec_i       (vec_in),
    .coef_o      (coef),
    .vec_o       (vec_m)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    qvr_lane #(
      .VECTOR_WIDTH (VECTOR_WIDTH),
      .QUAT_WIDTH   (QUAT_WIDTH)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (coef[g]),
      .vec_i  (vec_m),
      .res_o  (res[g]),
      .sat_o  (sat[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= ODW'({res[2], res[1], res[0]});
      m_axis_tuser <= |sat;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qvr_matrix.sv =====
// Rotation matrix builder: quaternion products, then the nine entries,
// ordered per lane for either direction. Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvr_matrix #(
  parameter int VECTOR_WIDTH = qvr_pkg::VECTOR_WIDTH_DEF,
  parameter int QUAT_WIDTH   = qvr_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic                           direction_i,
  input  wire logic signed [QUAT_WIDTH-1:0]   quat_w_i,
  input  wire logic signed [QUAT_WIDTH-1:0]   quat_x_i,
  input  wire logic signed [QUAT_WIDTH-1:0]   quat_y_i,
  input  wire logic signed [QUAT_WIDTH-1:0]   quat_z_i,
  input  wire logic signed [VECTOR_WIDTH-1:0] vec_i [qvr_pkg::NUM_LANES],
  output logic signed [2*QUAT_WIDTH+1:0]
    coef_o [qvr_pkg::NUM_LANES][qvr_pkg::NUM_LANES],
  output logic signed [VECTOR_WIDTH-1:0]      vec_o [qvr_pkg::NUM_LANES]
);
  import qvr_pkg::*;

  localparam int PW = 2 * QUAT_WIDTH;
  localparam int EW = 2 * QUAT_WIDTH + 2;
  localparam logic signed [EW-1:0] ONE = {{(EW-1){1'b0}}, 1'b1} << (2 * QUAT_WIDTH - 4);

  logic signed [PW-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q, pwx_q, pwy_q, pwz_q;
  logic                 dir_q;
  logic signed [VECTOR_WIDTH-1:0] vec1_q [NUM_LANES];
  logic signed [EW-1:0] m [NUM_LANES][NUM_LANES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxx_q  <= quat_x_i * quat_x_i;
      pyy_q  <= quat_y_i * quat_y_i;
      pzz_q  <= quat_z_i * quat_z_i;
      pxy_q  <= quat_x_i * quat_y_i;
      pxz_q  <= quat_x_i * quat_z_i;
      pyz_q  <= quat_y_i * quat_z_i;
      pwx_q  <= quat_w_i * quat_x_i;
      pwy_q  <= quat_w_i * quat_y_i;
      pwz_q  <= quat_w_i * quat_z_i;
      dir_q  <= direction_i;
      vec1_q <= vec_i;
    end
  end

  always_comb begin
    m[0][0] = ONE - ((EW'(pyy_q) + EW'(pzz_q)) <<< 1);
    m[0][1] = (EW'(pxy_q) - EW'(pwz_q)) <<< 1;
    m[0][2] = (EW'(pxz_q) + EW'(pwy_q)) <<< 1;
    m[1][0] = (EW'(pxy_q) + EW'(pwz_q)) <<< 1;
    m[1][1] = ONE - ((EW'(pxx_q) + EW'(pzz_q)) <<< 1);
    m[1][2] = (EW'(pyz_q) - EW'(pwx_q)) <<< 1;
    m[2][0] = (EW'(pxz_q) - EW'(pwy_q)) <<< 1;
    m[2][1] = (EW'(pyz_q) + EW'(pwx_q)) <<< 1;
    m[2][2] = ONE - ((EW'(pxx_q) + EW'(pyy_q)) <<< 1);
  end

  // The transposed matrix serves the earth to body direction.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        for (int j = 0; j < NUM_LANES; j++) begin
          coef_o[i][j] <= dir_q ? m[j][i] : m[i][j];
        end
      end
      vec_o <= vec1_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qvr_lane.sv =====
// One output axis: dot product of a matrix row with the vector, split into
// partial products, then rounding and saturation. Depends on qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvr_lane #(
  parameter int VECTOR_WIDTH = qvr_pkg::VECTOR_WIDTH_DEF,
  parameter int QUAT_WIDTH   = qvr_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic signed [2*QUAT_WIDTH+1:0] coef_i [qvr_pkg::NUM_LANES],
  input  wire logic signed [VECTOR_WIDTH-1:0] vec_i  [qvr_pkg::NUM_LANES],
  output logic signed [VECTOR_WIDTH:0]        res_o,
  output logic                                sat_o
);
  import qvr_pkg::*;

  localparam int QW  = QUAT_WIDTH;
  localparam int EW  = 2 * QW + 2;
  localparam int LW  = QW + 1 + VECTOR_WIDTH;
  localparam int HW  = QW + 2 + VECTOR_WIDTH;
  localparam int SLW = LW + 2;
  localparam int SHW = HW + 2;
  localparam int AW  = SHW + QW + 1;
  localparam int F2  = 2 * QW - 4;
  localparam int RW  = AW - F2;
  localparam int OW  = VECTOR_WIDTH + 1;
  localparam logic signed [AW-1:0] RND = {{(AW-1){1'b0}}, 1'b1} << (F2 - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << VECTOR_WIDTH) - 64'd1);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  logic        [QW-1:0]  lo_part [NUM_LANES];
  logic signed [QW+1:0]  hi_part [NUM_LANES];
  logic signed [LW-1:0]  lov_q   [NUM_LANES];
  logic signed [HW-1:0]  hiv_q   [NUM_LANES];
  logic signed [SLW-1:0] slo_q;
  logic signed [SHW-1:0] shi_q;
  logic signed [AW-1:0]  acc;
  logic signed [RW-1:0]  rnd;

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      lo_part[j] = coef_i[j][QW-1:0];
      hi_part[j] = coef_i[j][EW-1:QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        lov_q[j] <= $signed({1'b0, lo_part[j]}) * vec_i[j];
        hiv_q[j] <= hi_part[j] * vec_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slo_q <= SLW'(lov_q[0]) + SLW'(lov_q[1]) + SLW'(lov_q[2]);
      shi_q <= SHW'(hiv_q[0]) + SHW'(hiv_q[1]) + SHW'(hiv_q[2]);
    end
  end

  always_comb begin
    acc = (AW'(shi_q) <<< QW) + AW'(slo_q) + RND;
    rnd = acc[AW-1:F2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rnd > SAT_HI) begin
        res_o <= SAT_HI[OW-1:0];
        sat_o <= 1'b1;
      end else if (rnd < SAT_LO) begin
        res_o <= SAT_LO[OW-1:0];
        sat_o <= 1'b1;
      end else begin
        res_o <= rnd[OW-1:0];
        sat_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
